>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit: shared definitions
// Word format, operation and status codes, and the classified item type
// passed from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd1;
  localparam logic [OP_W-1:0] OP_CONJ = 3'd2;
  localparam logic [OP_W-1:0] OP_DIVR = 3'd3;
  localparam logic [OP_W-1:0] OP_DIVC = 3'd4;

  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_DZ  = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT = 2'd2;

  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_MUL,
    KIND_CONJ,
    KIND_DIVR,
    KIND_DIVC,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic                         dz;
    logic signed [WORD_BITS-1:0]  a_re;
    logic signed [WORD_BITS-1:0]  a_im;
    logic signed [WORD_BITS-1:0]  b_re;
    logic signed [WORD_BITS-1:0]  b_im;
    logic signed [WORD_BITS-1:0]  divisor;
  } item_t;

endpackage

>>> rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit: front end
// Takes request transfers, decodes the operation and flags division by zero,
// and holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [cau_pkg::OP_W-1:0]             operation,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] divisor,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output cau_pkg::item_t                       push_item
);
  import cau_pkg::*;

  logic  valid;
  item_t item;
  kind_t kind;
  logic  dz;

  always_comb begin
    case (operation)
      OP_ADD:  kind = KIND_ADD;
      OP_MUL:  kind = KIND_MUL;
      OP_CONJ: kind = KIND_CONJ;
      OP_DIVR: kind = KIND_DIVR;
      OP_DIVC: kind = KIND_DIVC;
      default: kind = KIND_NONE;
    endcase
  end

  assign dz = ((kind == KIND_DIVR) && (divisor == '0)) ||
              ((kind == KIND_DIVC) && (b_re == '0) && (b_im == '0));

  assign req_ready  = !valid || push_ready;
  assign push_valid = valid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= '{kind: kind, dz: dz, a_re: a_re, a_im: a_im,
                b_re: b_re, b_im: b_im, divisor: divisor};
    end
  end

endmodule

>>> rtl/core/cau_queue.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit: item queue
// Short FIFO between front and back end so that each side stalls on its own.
// ----------------------------------------------------------------------------
module cau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  cau_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output cau_pkg::item_t rd_item
);
  import cau_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign wr_ready = count != (PW+1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

>>> rtl/core/cau_back.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit: back end
// Multiplier stage, operand combine, magnitude, rounding and dividend set-up,
// a pipelined restoring divider per lane, then saturation into the output
// register. The whole pipeline moves when the output register can take data.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  cau_pkg::item_t                       item,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_im,
  output logic [cau_pkg::ST_W-1:0]             status
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 2;
  localparam int MW = 2 * W + 1;
  localparam int DW = 2 * W + 1;
  localparam int NW = MW + F + 2;
  localparam int QB = W + 1;
  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int RW = DW + 1;
  localparam int NL = 2;

  localparam logic [MW:0]   HALF    = (F > 0) ? ((MW+1)'(1) << ((F > 0) ? F - 1 : 0)) : '0;
  localparam logic [MW-1:0] LIM_POS = (MW'(1) << (W - 1)) - MW'(1);
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W - 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  dz;
  } ctl_t;

  logic advance;

  // products
  ctl_t                 s1_ctl;
  item_t                s1_item;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;

  // combined operands
  ctl_t                 s2_ctl;
  logic signed [VW-1:0] s2_v [NL];
  logic signed [VW-1:0] s2_v_next [NL];
  logic [PW-1:0]        s2_dd, s2_dd_next;
  logic                 s2_dneg, s2_dneg_next;
  logic signed [W:0]    dv_ext;
  logic [W:0]           dv_mag;

  // magnitudes
  ctl_t                 s3_ctl;
  logic                 s3_neg [NL];
  logic [MW-1:0]        s3_mag [NL];
  logic [PW-1:0]        s3_dd;
  logic                 s3_dneg;

  // rounding and dividend set-up
  ctl_t                 s4_ctl;
  logic [MW-1:0]        s4_val [NL];
  logic [NW-1:0]        s4_n2 [NL];
  logic                 s4_sgn [NL];
  logic [DW-1:0]        s4_d2;

  // divider stages
  ctl_t                 d_ctl [QB+1];
  logic [DW-1:0]        d_d2  [QB+1];
  logic [MW-1:0]        d_val [QB+1][NL];
  logic                 d_sgn [QB+1][NL];
  logic                 d_ovf [QB+1][NL];
  logic [RW-1:0]        d_r   [QB+1][NL];
  logic [QB-1:0]        d_lo  [QB+1][NL];
  logic [QB-1:0]        d_q   [QB+1][NL];
  logic [RW-1:0]        step_r [QB][NL];
  logic [QB-1:0]        step_q [QB][NL];

  // final
  logic                 fin_isdiv;
  logic                 fin_over [NL];
  logic [W-1:0]         fin_word [NL];
  logic [MW-1:0]        fin_mag [NL];
  logic [MW-1:0]        fin_lim [NL];
  logic [W-1:0]         fin_res [NL];
  logic [ST_W-1:0]      fin_status;

  assign advance    = !rsp_valid || rsp_ready;
  assign item_ready = advance;

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl    <= '0;
      s2_ctl    <= '0;
      s3_ctl    <= '0;
      s4_ctl    <= '0;
      for (int k = 0; k <= QB; k++) begin
        d_ctl[k] <= '0;
      end
      rsp_valid <= 1'b0;
    end else if (advance) begin
      s1_ctl <= '{valid: item_valid, kind: item.kind, dz: item.dz};
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
      s4_ctl <= s3_ctl;
      d_ctl[0] <= s4_ctl;
      for (int k = 0; k < QB; k++) begin
        d_ctl[k+1] <= d_ctl[k];
      end
      rsp_valid <= d_ctl[QB].valid;
    end
  end

  // --------------------------------------------------------------------------
  // combine
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      s2_v_next[l] = '0;
    end
    s2_dd_next   = '0;
    s2_dneg_next = 1'b0;
    dv_ext       = (W+1)'(s1_item.divisor);
    dv_mag       = s1_item.divisor[W-1] ? (W+1)'(-dv_ext) : (W+1)'(dv_ext);
    case (s1_ctl.kind)
      KIND_ADD: begin
        s2_v_next[0] = VW'(s1_item.a_re) + VW'(s1_item.b_re);
        s2_v_next[1] = VW'(s1_item.a_im) + VW'(s1_item.b_im);
      end
      KIND_MUL: begin
        s2_v_next[0] = VW'(p_rr) - VW'(p_ii);
        s2_v_next[1] = VW'(p_ri) + VW'(p_ir);
      end
      KIND_CONJ: begin
        s2_v_next[0] = VW'(s1_item.a_re);
        s2_v_next[1] = -VW'(s1_item.a_im);
      end
      KIND_DIVR: begin
        s2_v_next[0] = VW'(s1_item.a_re);
        s2_v_next[1] = VW'(s1_item.a_im);
        s2_dd_next   = PW'(dv_mag);
        s2_dneg_next = s1_item.divisor[W-1];
      end
      KIND_DIVC: begin
        s2_v_next[0] = VW'(p_rr) + VW'(p_ii);
        s2_v_next[1] = VW'(p_ir) - VW'(p_ri);
        s2_dd_next   = $unsigned(p_bb) + $unsigned(p_cc);
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // divider steps
  // --------------------------------------------------------------------------
  always_comb begin
    logic [RW-1:0] t;
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < NL; l++) begin
        t = {d_r[k][l][RW-2:0], d_lo[k][l][QB-1-k]};
        if (t >= RW'(d_d2[k])) begin
          step_r[k][l] = t - RW'(d_d2[k]);
          step_q[k][l] = {d_q[k][l][QB-2:0], 1'b1};
        end else begin
          step_r[k][l] = t;
          step_q[k][l] = {d_q[k][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // saturation and status
  // --------------------------------------------------------------------------
  always_comb begin
    fin_isdiv = (d_ctl[QB].kind == KIND_DIVR) || (d_ctl[QB].kind == KIND_DIVC);
    for (int l = 0; l < NL; l++) begin
      fin_mag[l]  = fin_isdiv ? MW'(d_q[QB][l]) : d_val[QB][l];
      fin_lim[l]  = d_sgn[QB][l] ? LIM_NEG : LIM_POS;
      fin_over[l] = (fin_isdiv && d_ovf[QB][l]) || (fin_mag[l] > fin_lim[l]);
      fin_word[l] = fin_over[l] ? fin_lim[l][W-1:0] : fin_mag[l][W-1:0];
      fin_res[l]  = d_sgn[QB][l] ? W'(-fin_word[l]) : fin_word[l];
    end
    if (d_ctl[QB].dz) begin
      fin_status = ST_DZ;
      fin_res[0] = '0;
      fin_res[1] = '0;
    end else if (fin_over[0] || fin_over[1]) begin
      fin_status = ST_SAT;
    end else begin
      fin_status = ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= item;
      p_rr    <= PW'(item.a_re) * PW'(item.b_re);
      p_ii    <= PW'(item.a_im) * PW'(item.b_im);
      p_ri    <= PW'(item.a_re) * PW'(item.b_im);
      p_ir    <= PW'(item.a_im) * PW'(item.b_re);
      p_bb    <= PW'(item.b_re) * PW'(item.b_re);
      p_cc    <= PW'(item.b_im) * PW'(item.b_im);

      s2_v    <= s2_v_next;
      s2_dd   <= s2_dd_next;
      s2_dneg <= s2_dneg_next;

      for (int l = 0; l < NL; l++) begin
        s3_neg[l] <= s2_v[l][VW-1];
        s3_mag[l] <= MW'(s2_v[l][VW-1] ? -s2_v[l] : s2_v[l]);
      end
      s3_dd   <= s2_dd;
      s3_dneg <= s2_dneg;

      for (int l = 0; l < NL; l++) begin
        s4_val[l] <= (s3_ctl.kind == KIND_MUL) ?
                     MW'(((MW+1)'(s3_mag[l]) + HALF) >> F) : s3_mag[l];
        s4_n2[l]  <= (NW'(s3_mag[l]) << (F + 1)) + NW'(s3_dd);
        s4_sgn[l] <= s3_neg[l] ^ ((s3_ctl.kind == KIND_DIVR) && s3_dneg);
      end
      s4_d2 <= {s3_dd, 1'b0};

      d_d2[0] <= s4_d2;
      for (int l = 0; l < NL; l++) begin
        d_val[0][l] <= s4_val[l];
        d_sgn[0][l] <= s4_sgn[l];
        d_ovf[0][l] <= CW'(s4_n2[l][NW-1:QB]) >= CW'(s4_d2);
        d_r[0][l]   <= RW'(s4_n2[l][NW-1:QB]);
        d_lo[0][l]  <= s4_n2[l][QB-1:0];
        d_q[0][l]   <= '0;
      end

      for (int k = 0; k < QB; k++) begin
        d_d2[k+1] <= d_d2[k];
        for (int l = 0; l < NL; l++) begin
          d_val[k+1][l] <= d_val[k][l];
          d_sgn[k+1][l] <= d_sgn[k][l];
          d_ovf[k+1][l] <= d_ovf[k][l];
          d_r[k+1][l]   <= step_r[k][l];
          d_lo[k+1][l]  <= d_lo[k][l];
          d_q[k+1][l]   <= step_q[k][l];
        end
      end

      res_re <= $signed(fin_res[0]);
      res_im <= $signed(fin_res[1]);
      status <= fin_status;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_DZ) |-> (res_re == '0) && (res_im == '0))
    else $error("divide by zero transfer with nonzero result");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_SAT) |->
      (res_re == WMAX) || (res_re == WMIN) || (res_im == WMAX) || (res_im == WMIN))
    else $error("saturated transfer without a clamped part");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    advance && d_ctl[QB].valid |=> rsp_valid)
    else $error("divider output lost before output register");
`endif

endmodule

>>> rtl/core/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// One transfer per clock, sustained while the result side takes results. Every
// operation takes the same path, through the 33-step pipelined restoring
// divider, so results leave in request order. A 4-entry queue between the
// decoder and the datapath keeps taking requests while the result side stalls,
// until it is full.
// Operands and results are signed Q16.16; out-of-range results saturate.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [cau_pkg::OP_W-1:0]             operation,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] divisor,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_im,
  output logic [cau_pkg::ST_W-1:0]             status
);
  import cau_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .operation  (operation),
    .a_re       (a_re),
    .a_im       (a_im),
    .b_re       (b_re),
    .b_im       (b_im),
    .divisor    (divisor),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  cau_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  cau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .res_re     (res_re),
    .res_im     (res_im),
    .status     (status)
  );

endmodule
